FILE: hw/rtl/ajb_pkg.sv
// Package for the audio jitter buffer: sizes, command codes and the
// control and status structs passed between the top level and the slot table.
// No dependencies.
`timescale 1ns / 1ps

package ajb_pkg;

  localparam int SLOTS     = 8;
  localparam int FRAME_LEN = 1024;
  localparam int NPHYS     = SLOTS + 1;
  localparam int DEPTH     = NPHYS * FRAME_LEN;

  localparam int IDX_W  = (NPHYS > 1) ? $clog2(NPHYS) : 1;
  localparam int CNT_W  = $clog2(FRAME_LEN + 1);
  localparam int HC_W   = $clog2(NPHYS + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SEQ_W  = 32;
  localparam int SMP_W  = 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic             scan_start;
    logic             clr_en;
    logic [IDX_W-1:0] clr_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [SEQ_W-1:0] wr_seq;
    logic [CNT_W-1:0] wr_len;
  } slot_cmd_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] best_idx;
    logic [SEQ_W-1:0] best_seq;
    logic [CNT_W-1:0] best_len;
    logic [NPHYS-1:0] held;
  } slot_stat_t;

  function automatic logic [ADDR_W-1:0] sample_addr(input logic [IDX_W-1:0] slot,
                                                    input logic [CNT_W-1:0] pos);
    sample_addr = ADDR_W'(slot) * ADDR_W'(FRAME_LEN) + ADDR_W'(pos);
  endfunction

endpackage

FILE: hw/rtl/ajb_slot_table.sv
// Slot table: per-slot sequence and length memory, held flags and the
// sequential lowest-sequence scan over the held slots.
// Depends on ajb_pkg.
`timescale 1ns / 1ps

module ajb_slot_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ajb_pkg::slot_cmd_t cmd_i,
  output ajb_pkg::slot_stat_t stat_o
);
  import ajb_pkg::*;

  logic [SEQ_W+CNT_W-1:0] meta_mem_q [NPHYS];
  logic [SEQ_W+CNT_W-1:0] meta_rdata_q;

  logic [NPHYS-1:0] held_q;
  logic             active_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             cmp_valid_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             done_q;
  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [SEQ_W-1:0] best_seq_q;
  logic [CNT_W-1:0] best_len_q;

  logic [SEQ_W-1:0] rd_seq;
  logic [CNT_W-1:0] rd_len;
  logic             take;
  logic             cmp_last;

  assign rd_seq   = meta_rdata_q[SEQ_W+CNT_W-1:CNT_W];
  assign rd_len   = meta_rdata_q[CNT_W-1:0];
  assign take     = cmp_valid_q && held_q[cmp_idx_q] && (!found_q || (rd_seq < best_seq_q));
  assign cmp_last = cmp_valid_q && (cmp_idx_q == IDX_W'(NPHYS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      meta_mem_q[cmd_i.wr_idx] <= {cmd_i.wr_seq, cmd_i.wr_len};
    end
    if (active_q) begin
      meta_rdata_q <= meta_mem_q[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q <= cmp_idx_q;
      best_seq_q <= rd_seq;
      best_len_q <= rd_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      active_q    <= 1'b0;
      rd_idx_q    <= '0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
      done_q      <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      for (int i = 0; i < NPHYS; i++) begin
        if (cmd_i.clr_en && (cmd_i.clr_idx == IDX_W'(i))) begin
          held_q[i] <= 1'b0;
        end else if (cmd_i.wr_en && (cmd_i.wr_idx == IDX_W'(i))) begin
          held_q[i] <= 1'b1;
        end
      end
      cmp_valid_q <= active_q;
      cmp_idx_q   <= rd_idx_q;
      done_q      <= cmp_last;
      if (cmd_i.scan_start) begin
        active_q <= 1'b1;
        rd_idx_q <= '0;
        found_q  <= 1'b0;
      end else begin
        if (active_q) begin
          if (rd_idx_q == IDX_W'(NPHYS - 1)) begin
            active_q <= 1'b0;
          end else begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.found    = found_q;
  assign stat_o.best_idx = best_idx_q;
  assign stat_o.best_seq = best_seq_q;
  assign stat_o.best_len = best_len_q;
  assign stat_o.held     = held_q;

endmodule

FILE: hw/rtl/audio_jitter_buffer.sv
// Audio jitter buffer top level: sample memory, fill and playback control.
// A write goes from idle to the write state, first running an eviction scan when a full buffer must free a slot.
// A read goes through the request and data states into the output register, after a slot table
// scan, one slot a cycle, when no frame is current; the data state waits while the output is held.
// One item is in flight at a time; a finished result may wait while the next is taken.
// Reset (asynchronous, active low) clears all control state; memories need no clearing.
`timescale 1ns / 1ps

module audio_jitter_buffer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             command_i,
  input  logic [ajb_pkg::SEQ_W-1:0]        frame_seq_i,
  input  logic signed [ajb_pkg::SMP_W-1:0] sample_in_i,
  input  logic                             frame_end_i,
  input  logic                             period_end_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [ajb_pkg::SMP_W-1:0] sample_out_o,
  output logic                             from_frame_o,
  output logic [ajb_pkg::SEQ_W-1:0]        played_seq_o
);
  import ajb_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WSCAN = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_RSCAN = 3'd3;
  localparam logic [2:0] ST_RREQ  = 3'd4;
  localparam logic [2:0] ST_RDATA = 3'd5;

  logic [2:0] state_q, state_d;

  logic [SEQ_W-1:0] seq_q;
  logic [SMP_W-1:0] smp_q;
  logic             fend_q;
  logic             pend_q;

  logic [IDX_W-1:0] fill_slot_q, fill_slot_d;
  logic [CNT_W-1:0] fill_count_q, fill_count_d;
  logic             fill_busy_q, fill_busy_d;
  logic [SEQ_W-1:0] fill_seq_q, fill_seq_d;

  logic [IDX_W-1:0] play_slot_q, play_slot_d;
  logic [CNT_W-1:0] play_pos_q, play_pos_d;
  logic             play_busy_q, play_busy_d;
  logic [SEQ_W-1:0] play_seq_q, play_seq_d;
  logic [CNT_W-1:0] play_len_q, play_len_d;

  logic             out_valid_q, out_valid_d;
  logic [SMP_W-1:0] out_smp_q;
  logic             out_from_q;
  logic [SEQ_W-1:0] out_seq_q;
  logic             out_load;

  logic [SMP_W-1:0] smp_mem_q [DEPTH];
  logic [SMP_W-1:0] smp_rdata_q;
  logic             smp_we;
  logic             smp_re;
  logic [ADDR_W-1:0] smp_addr;

  slot_cmd_t  tcmd;
  slot_stat_t stat;

  logic [HC_W-1:0]  held_cnt;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] eff_slot;
  logic [CNT_W-1:0] eff_cnt;
  logic [SEQ_W-1:0] eff_seq;
  logic [CNT_W-1:0] pos_next;

  ajb_slot_table u_slot_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (tcmd),
    .stat_o (stat)
  );

  always_comb begin
    held_cnt   = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < NPHYS; i++) begin
      held_cnt = held_cnt + HC_W'(stat.held[i]);
      if (!free_found && !stat.held[i] && !(play_busy_q && (play_slot_q == IDX_W'(i)))) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign eff_slot = fill_busy_q ? fill_slot_q : free_idx;
  assign eff_cnt  = fill_busy_q ? fill_count_q : '0;
  assign eff_seq  = fill_busy_q ? fill_seq_q : seq_q;
  assign pos_next = play_pos_q + 1'b1;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    tcmd         = '0;
    smp_we       = 1'b0;
    smp_re       = 1'b0;
    smp_addr     = sample_addr(play_slot_q, play_pos_q);
    fill_slot_d  = fill_slot_q;
    fill_count_d = fill_count_q;
    fill_busy_d  = fill_busy_q;
    fill_seq_d   = fill_seq_q;
    play_slot_d  = play_slot_q;
    play_pos_d   = play_pos_q;
    play_busy_d  = play_busy_q;
    play_seq_d   = play_seq_q;
    play_len_d   = play_len_q;
    out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (command_i == CMD_WRITE) begin
            if (!fill_busy_q && (held_cnt >= HC_W'(SLOTS))) begin
              tcmd.scan_start = 1'b1;
              state_d         = ST_WSCAN;
            end else begin
              state_d = ST_WRITE;
            end
          end else if (!play_busy_q) begin
            tcmd.scan_start = 1'b1;
            state_d         = ST_RSCAN;
          end else begin
            state_d = ST_RREQ;
          end
        end
      end
      ST_WSCAN: begin
        if (stat.done) begin
          if (stat.found) begin
            tcmd.clr_en  = 1'b1;
            tcmd.clr_idx = stat.best_idx;
          end
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
        if (fill_busy_q || free_found) begin
          fill_slot_d = eff_slot;
          fill_seq_d  = eff_seq;
          fill_busy_d = 1'b1;
          if (eff_cnt < CNT_W'(FRAME_LEN)) begin
            smp_we       = 1'b1;
            smp_addr     = sample_addr(eff_slot, eff_cnt);
            fill_count_d = eff_cnt + 1'b1;
          end else begin
            fill_count_d = eff_cnt;
          end
          if (fend_q) begin
            tcmd.wr_en  = 1'b1;
            tcmd.wr_idx = eff_slot;
            tcmd.wr_seq = eff_seq;
            tcmd.wr_len = fill_count_d;
            fill_busy_d = 1'b0;
          end
        end
      end
      ST_RSCAN: begin
        if (stat.done) begin
          if (stat.found) begin
            tcmd.clr_en  = 1'b1;
            tcmd.clr_idx = stat.best_idx;
            play_slot_d  = stat.best_idx;
            play_pos_d   = '0;
            play_busy_d  = 1'b1;
            play_seq_d   = stat.best_seq;
            play_len_d   = stat.best_len;
          end
          state_d = ST_RREQ;
        end
      end
      ST_RREQ: begin
        smp_re  = play_busy_q;
        state_d = ST_RDATA;
      end
      ST_RDATA: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (play_busy_q) begin
            play_pos_d = pos_next;
            if (pos_next >= play_len_q) begin
              play_busy_d = 1'b0;
            end
          end
          if (pend_q) begin
            play_busy_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      smp_mem_q[smp_addr] <= smp_q;
    end
    if (smp_re) begin
      smp_rdata_q <= smp_mem_q[smp_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      seq_q  <= frame_seq_i;
      smp_q  <= sample_in_i;
      fend_q <= frame_end_i;
      pend_q <= period_end_i;
    end
    if (out_load) begin
      out_smp_q  <= play_busy_q ? smp_rdata_q : '0;
      out_from_q <= play_busy_q;
      out_seq_q  <= play_busy_q ? play_seq_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_seq_q <= fill_seq_d;
    play_seq_q <= play_seq_d;
    play_len_q <= play_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_slot_q  <= '0;
      fill_count_q <= '0;
      fill_busy_q  <= 1'b0;
      play_slot_q  <= '0;
      play_pos_q   <= '0;
      play_busy_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_slot_q  <= fill_slot_d;
      fill_count_q <= fill_count_d;
      fill_busy_q  <= fill_busy_d;
      play_slot_q  <= play_slot_d;
      play_pos_q   <= play_pos_d;
      play_busy_q  <= play_busy_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_smp_q;
  assign from_frame_o = out_from_q;
  assign played_seq_o = out_seq_q;

  a_silence_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !from_frame_o) |-> (sample_out_o == '0 && played_seq_o == '0))
    else $error("silence result carries non-zero payload");

  a_fill_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_busy_q |-> !stat.held[fill_slot_q])
    else $error("slot being filled is marked held");

  a_play_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    play_busy_q |-> !stat.held[play_slot_q])
    else $error("slot being played is marked held");

  a_fill_play_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_busy_q && play_busy_q) |-> (fill_slot_q != play_slot_q))
    else $error("fill and playback share a slot");

endmodule
